### hdl/rgba_color_matrix_transform_core_defines.svh
// Assertion macros shared by the color matrix RTL.
`ifndef RGBA_COLOR_MATRIX_TRANSFORM_CORE_DEFINES_SVH
`define RGBA_COLOR_MATRIX_TRANSFORM_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define RCMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, evaluated through reset as well.
`define RCMT_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/rcmt_pkg.sv
`default_nettype none
package rcmt_pkg;
    localparam int COEF_WIDTH_DEF = 12;
    localparam int COEF_FRAC_DEF  = 8;
    localparam int NUM_ROWS       = 5;
    localparam int NUM_COLS       = 5;
    localparam int NUM_CHAN       = 4;
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = NUM_CHAN * CHAN_W;
    localparam int CFG_IDX_W      = 3;
    localparam int QUOT_BITS      = 8;
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // Pipeline stage numbering
    localparam int STG_PROD  = 0;
    localparam int STG_SUM   = 1;
    localparam int STG_SCALE = 2;
    localparam int STG_SIGN  = 3;
    localparam int STG_DIV0  = 4;
    localparam int STG_OUT   = STG_DIV0 + QUOT_BITS;
    localparam int NUM_STG   = STG_OUT + 1;

    typedef struct packed {
        logic [NUM_STG-1:0] ce;
    } t_pipe_ctl;
endpackage
`default_nettype wire

### hdl/rcmt_dot.sv
`default_nettype none
module rcmt_dot #(
    parameter int COEF_WIDTH = rcmt_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                                      i_clk,
    input  wire rcmt_pkg::t_pipe_ctl                       i_ctl,
    input  wire logic [rcmt_pkg::NUM_COLS*COEF_WIDTH-1:0]  i_row,
    input  wire logic [rcmt_pkg::PIX_W-1:0]                i_pix,
    output logic signed [COEF_WIDTH+rcmt_pkg::CHAN_W+3:0]  o_acc
);
    import rcmt_pkg::*;

    localparam int PROD_W = COEF_WIDTH + CHAN_W + 1;
    localparam int ACC_W  = PROD_W + 3;

    logic signed [PROD_W-1:0] r_prod [NUM_COLS];
    logic signed [PROD_W-1:0] n_prod [NUM_COLS];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        logic signed [COEF_WIDTH-1:0] coef;
        logic signed [CHAN_W:0]       opnd;
        for (int j = 0; j < NUM_COLS; j++) begin
            coef = signed'(i_row[j*COEF_WIDTH +: COEF_WIDTH]);
            if (j < NUM_CHAN) begin
                opnd = signed'({1'b0, i_pix[j*CHAN_W +: CHAN_W]});
            end else begin
                opnd = signed'({1'b0, FULL_SCALE});
            end
            n_prod[j] = PROD_W'(coef) * PROD_W'(opnd);
        end
    end

    always_comb begin
        n_acc = '0;
        for (int j = 0; j < NUM_COLS; j++) begin
            n_acc = n_acc + ACC_W'(r_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce[STG_PROD]) begin
            r_prod <= n_prod;
        end
        if (i_ctl.ce[STG_SUM]) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

### hdl/rcmt_div.sv
`default_nettype none
module rcmt_div #(
    parameter int COEF_WIDTH     = rcmt_pkg::COEF_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = rcmt_pkg::COEF_FRAC_DEF
) (
    input  wire logic                                      i_clk,
    input  wire rcmt_pkg::t_pipe_ctl                       i_ctl,
    input  wire logic signed [COEF_WIDTH+rcmt_pkg::CHAN_W+3:0] i_num,
    input  wire logic signed [COEF_WIDTH+rcmt_pkg::CHAN_W+3:0] i_den,
    output logic [rcmt_pkg::CHAN_W-1:0]                    o_chan
);
    import rcmt_pkg::*;

    localparam int ACC_W = COEF_WIDTH + CHAN_W + 4;
    localparam int A_W   = ACC_W + CHAN_W;

    typedef struct packed {
        logic [A_W-1:0]       rem;
        logic [A_W-1:0]       dmag;
        logic [QUOT_BITS-1:0] q;
        logic                 zero;
        logic                 full;
        logic                 byp;
    } t_div_stage;

    logic signed [A_W-1:0]   r_a;
    logic signed [ACC_W-1:0] r_n;
    logic signed [ACC_W-1:0] r_d;
    t_div_stage              r_st [QUOT_BITS+1];
    t_div_stage              n_st [QUOT_BITS+1];

    always_comb begin
        logic signed [ACC_W-1:0] sh;
        logic [A_W-1:0]          amag;
        logic [A_W-1:0]          dmag;
        logic                    opp;
        logic [A_W-1:0]          dsh;
        // Sign, magnitude and range check ahead of the bit stages
        sh   = r_n >>> COEF_FRAC_BITS;
        amag = r_a[A_W-1] ? A_W'(-r_a) : A_W'(r_a);
        dmag = r_d[ACC_W-1] ? A_W'(-r_d) : A_W'(r_d);
        opp  = (r_a[A_W-1] != r_d[ACC_W-1]) || (r_a == '0);
        n_st[0].rem  = amag;
        n_st[0].dmag = dmag;
        if (r_d == '0) begin
            n_st[0].byp  = 1'b1;
            n_st[0].zero = 1'b0;
            n_st[0].full = 1'b0;
            if (r_n[ACC_W-1]) begin
                n_st[0].q = '0;
            end else if ($unsigned(sh) > ACC_W'(FULL_SCALE)) begin
                n_st[0].q = FULL_SCALE;
            end else begin
                n_st[0].q = sh[QUOT_BITS-1:0];
            end
        end else begin
            n_st[0].byp  = 1'b0;
            n_st[0].q    = '0;
            n_st[0].zero = opp;
            n_st[0].full = !opp && (amag >= (dmag << QUOT_BITS));
        end

        // One quotient bit per stage, most significant first
        for (int k = 0; k < QUOT_BITS; k++) begin
            n_st[k+1] = r_st[k];
            dsh = r_st[k].dmag << (QUOT_BITS - 1 - k);
            if (!r_st[k].byp && !r_st[k].zero && !r_st[k].full && (r_st[k].rem >= dsh)) begin
                n_st[k+1].rem = r_st[k].rem - dsh;
                n_st[k+1].q[QUOT_BITS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce[STG_SCALE]) begin
            r_a <= (A_W'(i_num) <<< CHAN_W) - A_W'(i_num);
            r_n <= i_num;
            r_d <= i_den;
        end
        if (i_ctl.ce[STG_SIGN]) begin
            r_st[0] <= n_st[0];
        end
        for (int k = 0; k < QUOT_BITS; k++) begin
            if (i_ctl.ce[STG_DIV0+k]) begin
                r_st[k+1] <= n_st[k+1];
            end
        end
    end

    always_comb begin
        if (r_st[QUOT_BITS].full) begin
            o_chan = FULL_SCALE;
        end else if (r_st[QUOT_BITS].zero) begin
            o_chan = '0;
        end else begin
            o_chan = r_st[QUOT_BITS].q;
        end
    end
endmodule
`default_nettype wire

### hdl/rgba_color_matrix_transform_core.sv
// RGBA 5x5 color matrix transform.
// Input stream (i_s_*): one RGBA pixel per transfer, 8 bits per channel.
// Output stream (o_m_*): one transformed RGBA pixel per input transfer, in order.
// Configuration: i_cfg_we writes row i_cfg_idx (0..4) of the matrix from
// i_cfg_data, five signed fixed-point coefficients; indexes above 4 are dropped.
// Write configuration only while no pixel is in flight.
// Pipeline from an input transfer to o_m_tvalid: multiply, sum, scale by 255, sign and
// range check, eight restoring-division stages (one quotient bit each), output.
// Throughput: one pixel per clock while the output is not stalled; the division is fully pipelined per lane.
// Stalls: each stage advances when it is empty or the next one advances, so
// bubbles collapse and o_s_tready stays high while any stage is free.
// Reset (synchronous, active low): empty the pipeline, load the identity matrix.
`default_nettype none
module rgba_color_matrix_transform_core #(
    parameter int COEF_WIDTH     = rcmt_pkg::COEF_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = rcmt_pkg::COEF_FRAC_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_cfg_we,
    input  wire logic [rcmt_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire logic [rcmt_pkg::NUM_COLS*COEF_WIDTH-1:0] i_cfg_data,
    input  wire logic                                     i_s_tvalid,
    output logic                                          o_s_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
    input  wire logic [rcmt_pkg::PIX_W-1:0]               i_s_tdata,
    output logic                                          o_m_tvalid,
    input  wire logic                                     i_m_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16], alpha_out [31:24]
    output logic [rcmt_pkg::PIX_W-1:0]                    o_m_tdata
);
    import rcmt_pkg::*;

    `include "rgba_color_matrix_transform_core_defines.svh"

    localparam int ROW_W = NUM_COLS * COEF_WIDTH;
    localparam int ACC_W = COEF_WIDTH + CHAN_W + 4;

    logic [ROW_W-1:0]        r_coef [NUM_ROWS];
    logic [NUM_STG-1:0]      r_vld;
    logic [NUM_STG-1:0]      n_vld;
    logic [PIX_W-1:0]        r_out;
    logic [PIX_W-1:0]        n_out;
    t_pipe_ctl               ctl;
    logic signed [ACC_W-1:0] acc [NUM_ROWS];

    // Stage enables: a stage moves when it is empty or its successor moves
    always_comb begin
        ctl.ce[STG_OUT] = !r_vld[STG_OUT] || i_m_tready;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            ctl.ce[k] = !r_vld[k] || ctl.ce[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (ctl.ce[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (ctl.ce[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    // Hold the matrix and the stage valid flags; reset to identity and empty, ignore writes beyond the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int i = 0; i < NUM_ROWS; i++) begin
                r_coef[i] <= ROW_W'(1 << COEF_FRAC_BITS) << (COEF_WIDTH * i);
            end
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_ROWS))) begin
                r_coef[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // One dot-product lane per matrix row; row four is the divisor
    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_dot
        rcmt_dot #(
            .COEF_WIDTH(COEF_WIDTH)
        ) u_dot (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_row (r_coef[g]),
            .i_pix (i_s_tdata),
            .o_acc (acc[g])
        );
    end

    // One divide lane per output channel, all sharing the divisor
    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_div
        rcmt_div #(
            .COEF_WIDTH    (COEF_WIDTH),
            .COEF_FRAC_BITS(COEF_FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_num  (acc[g]),
            .i_den  (acc[NUM_ROWS-1]),
            .o_chan (n_out[g*CHAN_W +: CHAN_W])
        );
    end

    // Merge the four channel lanes into the output register
    always_ff @(posedge i_clk) begin
        if (ctl.ce[STG_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_s_tready = ctl.ce[0];
    assign o_m_tvalid = r_vld[STG_OUT];
    assign o_m_tdata  = r_out;

    `RCMT_ASSERT_IMP(a_ready_when_out_free, i_clk, i_rst_n, !r_vld[STG_OUT], o_s_tready)
    `RCMT_ASSERT_IMP(a_stall_when_full, i_clk, i_rst_n, (&r_vld) && !i_m_tready, !o_s_tready)
    `RCMT_ASSERT_NXT(a_empty_after_reset, i_clk, !i_rst_n, !o_m_tvalid && (r_vld == '0))
endmodule
`default_nettype wire
